// ===== src/bplpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bplpc_pkg
// Shared types and constants of the button press and long-press classifier.
// ----------------------------------------------------------------------------
package bplpc_pkg;

  localparam int unsigned NumButtonsDefault = 8;
  localparam int unsigned MaskW             = 8;
  localparam int unsigned DeltaW            = 16;
  localparam int unsigned TimeW             = 32;
  localparam int unsigned LongW             = 16;
  localparam int unsigned IndexW            = 3;
  localparam int unsigned FlagsW            = 7;

  localparam logic [LongW-1:0] LongPressReset = LongW'(500);

  // flag bit positions
  localparam int unsigned FlagReleased     = 0;
  localparam int unsigned FlagPressed      = 1;
  localparam int unsigned FlagLong         = 2;
  localparam int unsigned FlagJustReleased = 3;
  localparam int unsigned FlagJustPressed  = 4;
  localparam int unsigned FlagJustLong     = 5;
  localparam int unsigned FlagRepeat       = 6;

  typedef struct packed {
    logic [MaskW-1:0]  pressed_mask;
    logic [MaskW-1:0]  repeat_mask;
    logic [DeltaW-1:0] frame_delta;
  } in_word_t;

  typedef struct packed {
    logic [IndexW-1:0] button_index;
    logic [FlagsW-1:0] button_flags;
    logic [TimeW-1:0]  held_time;
    logic              last_of_frame;
  } out_word_t;

  typedef struct packed {
    logic [FlagsW-1:0] flags;
    logic [TimeW-1:0]  held;
  } lane_res_t;

endpackage

// ===== src/bplpc_lane.sv =====
// ----------------------------------------------------------------------------
// bplpc_lane
// One button: press state, press start times and classification of the frame.
// ----------------------------------------------------------------------------
module bplpc_lane (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic                     pressed_i,
  input  logic                     repeat_i,
  input  logic [bplpc_pkg::TimeW-1:0] frame_time_i,
  input  logic [bplpc_pkg::TimeW-1:0] prior_frame_time_i,
  input  logic [bplpc_pkg::LongW-1:0] long_press_i,
  output bplpc_pkg::lane_res_t     res_o
);
  import bplpc_pkg::*;

  logic             held_now_q, held_before_q, rep_q;
  logic [TimeW-1:0] start_q, prior_start_q;
  logic [TimeW-1:0] now_dur, before_dur;
  logic             now_long, before_long;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_now_q    <= 1'b0;
      held_before_q <= 1'b0;
      rep_q         <= 1'b0;
      start_q       <= '0;
      prior_start_q <= '0;
    end else if (accept_i) begin
      held_before_q <= held_now_q;
      held_now_q    <= pressed_i;
      rep_q         <= repeat_i;
      prior_start_q <= start_q;
      if (pressed_i && !held_now_q) begin
        start_q <= frame_time_i;
      end
    end
  end

  assign now_dur     = frame_time_i - start_q;
  assign before_dur  = prior_frame_time_i - prior_start_q;
  assign now_long    = now_dur >= TimeW'(long_press_i);
  assign before_long = before_dur >= TimeW'(long_press_i);

  always_comb begin
    res_o = '0;
    if (held_now_q) begin
      res_o.flags[FlagPressed]     = 1'b1;
      res_o.flags[FlagJustPressed] = !held_before_q;
      res_o.flags[FlagRepeat]      = rep_q;
      res_o.flags[FlagLong]        = now_long;
      res_o.flags[FlagJustLong]    = now_long && !before_long;
      res_o.held                   = now_dur;
    end else begin
      res_o.flags[FlagReleased] = 1'b1;
      if (held_before_q) begin
        res_o.flags[FlagJustReleased] = 1'b1;
        res_o.flags[FlagLong]         = before_long;
        res_o.held                    = before_dur;
      end
    end
  end

endmodule

// ===== src/bplpc_drain.sv =====
// ----------------------------------------------------------------------------
// bplpc_drain
// Captures a frame's lane results, hands out one word a cycle unless stalled.
// ----------------------------------------------------------------------------
module bplpc_drain #(
  parameter int unsigned NumButtons = bplpc_pkg::NumButtonsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  output logic                  in_stall_o,
  input  bplpc_pkg::lane_res_t  lane_res_i [NumButtons],
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bplpc_pkg::out_word_t  out_word_o
);
  import bplpc_pkg::*;

  localparam int unsigned CntW = (NumButtons > 1) ? $clog2(NumButtons) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(NumButtons - 1);

  lane_res_t       bank_q [NumButtons];
  logic [CntW-1:0] cnt_q;
  logic            bank_valid_q, eval_q;
  logic            last_taken, load_bank;
  logic [CntW+IndexW-1:0] idx_ext;

  assign last_taken = bank_valid_q && !out_stall_i && (cnt_q == LastCnt);
  assign load_bank  = eval_q && (!bank_valid_q || last_taken);
  assign in_stall_o = eval_q && !load_bank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q       <= 1'b0;
      bank_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (accept_i) begin
        eval_q <= 1'b1;
      end else if (load_bank) begin
        eval_q <= 1'b0;
      end
      if (load_bank) begin
        bank_valid_q <= 1'b1;
        cnt_q        <= '0;
      end else if (last_taken) begin
        bank_valid_q <= 1'b0;
      end else if (bank_valid_q && !out_stall_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_bank) begin
      bank_q <= lane_res_i;
    end
  end

  assign idx_ext     = {{IndexW{1'b0}}, cnt_q};
  assign out_valid_o = bank_valid_q;

  always_comb begin
    out_word_o.button_index  = idx_ext[IndexW-1:0];
    out_word_o.button_flags  = bank_q[cnt_q].flags;
    out_word_o.held_time     = bank_q[cnt_q].held;
    out_word_o.last_of_frame = (cnt_q == LastCnt);
  end

endmodule

// ===== src/button_press_long_press_classifier.sv =====
// ----------------------------------------------------------------------------
// button_press_long_press_classifier
// Per-button press, release, repeat and long-press classification of frames.
// ----------------------------------------------------------------------------
//  port group      dir   handshake               word
//  in_*            in    in_valid_i / in_stall_o   masks and frame delta
//  out_*           out   out_valid_o / out_stall_i one button result
//  cfg_*           in    cfg_we_i                  long press threshold
//
//  one frame gives NumButtons words, one per cycle while out_stall_i is
//  low; the output bank drain sets that rate
//  a taken frame waits in the lanes while the bank drains, then loads into
//  the output bank, which makes its first word valid; while it waits the
//  input stalls until the last word of the bank goes out
//  reset clears all press state, frame time and the threshold to 500 ms
// ----------------------------------------------------------------------------
module button_press_long_press_classifier #(
  parameter int unsigned NumButtons = bplpc_pkg::NumButtonsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bplpc_pkg::in_word_t         in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bplpc_pkg::out_word_t        out_word_o,
  input  logic                        cfg_we_i,
  input  logic [bplpc_pkg::LongW-1:0] cfg_data_i
);
  import bplpc_pkg::*;

  logic             accept;
  logic [TimeW-1:0] frame_time_q, prior_frame_time_q;
  logic [LongW-1:0] long_press_q;
  lane_res_t        lane_res [NumButtons];

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_time_q       <= '0;
      prior_frame_time_q <= '0;
      long_press_q       <= LongPressReset;
    end else begin
      if (cfg_we_i) begin
        long_press_q <= cfg_data_i;
      end
      if (accept) begin
        prior_frame_time_q <= frame_time_q;
        frame_time_q       <= frame_time_q + TimeW'(in_word_i.frame_delta);
      end
    end
  end

  for (genvar g = 0; g < NumButtons; g++) begin : g_lane
    logic pressed, rep;
    if (g < MaskW) begin : g_in
      assign pressed = in_word_i.pressed_mask[g];
      assign rep     = in_word_i.repeat_mask[g];
    end else begin : g_none
      assign pressed = 1'b0;
      assign rep     = 1'b0;
    end

    bplpc_lane u_lane (
      .clk_i              (clk_i),
      .rst_ni             (rst_ni),
      .accept_i           (accept),
      .pressed_i          (pressed),
      .repeat_i           (rep),
      .frame_time_i       (frame_time_q),
      .prior_frame_time_i (prior_frame_time_q),
      .long_press_i       (long_press_q),
      .res_o              (lane_res[g])
    );
  end

  bplpc_drain #(
    .NumButtons (NumButtons)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_stall_o  (in_stall_o),
    .lane_res_i  (lane_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== dv/bplpc_frame_checker.sv =====
// ----------------------------------------------------------------------------
// bplpc_frame_checker
// Watches the frame and result channels of the button classifier, predicts
// the NumButtons result words of every frame taken and compares each result word
// that leaves the block against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bplpc_frame_checker #(
  parameter int unsigned NumButtons = bplpc_pkg::NumButtonsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  bplpc_pkg::in_word_t         in_word_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  bplpc_pkg::out_word_t        out_word_i,
  input  logic                        cfg_we_i,
  input  logic [bplpc_pkg::LongW-1:0] cfg_data_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 words_checked_o
);
  import bplpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic [LongW-1:0] long_thr_ms;
  logic [TimeW-1:0] clock_ms;
  logic [TimeW-1:0] clock_before_ms;
  logic             down_now    [NumButtons];
  logic             down_before [NumButtons];
  logic [TimeW-1:0] start_ms        [NumButtons];
  logic [TimeW-1:0] start_before_ms [NumButtons];

  out_word_t   button_results_q[$];
  int unsigned fails   = 0;
  int unsigned checked = 0;

  assign fail_count_o    = fails;
  assign pending_o       = button_results_q.size();
  assign words_checked_o = checked;

  task automatic classify_frame(input in_word_t w);
    logic             p;
    logic             rep;
    logic             before_long;
    logic [TimeW-1:0] now_dur;
    logic [TimeW-1:0] before_dur;
    out_word_t        r;
    for (int b = 0; b < NumButtons; b++) begin
      p = (b < MaskW) ? w.pressed_mask[b] : 1'b0;
      start_before_ms[b] = start_ms[b];
      if (p && !down_now[b]) begin
        start_ms[b] = clock_ms;
      end
      down_before[b] = down_now[b];
      down_now[b]    = p;
    end
    clock_before_ms = clock_ms;
    clock_ms        = clock_ms + TimeW'(w.frame_delta);

    for (int b = 0; b < NumButtons; b++) begin
      rep         = (b < MaskW) ? w.repeat_mask[b] : 1'b0;
      now_dur     = clock_ms - start_ms[b];
      before_dur  = clock_before_ms - start_before_ms[b];
      before_long = before_dur >= TimeW'(long_thr_ms);
      r           = '0;
      r.button_index = IndexW'(b);
      if (down_now[b]) begin
        r.button_flags[FlagPressed] = 1'b1;
        r.button_flags[FlagJustPressed] = !down_before[b];
        r.button_flags[FlagRepeat] = rep;
        if (now_dur >= TimeW'(long_thr_ms)) begin
          r.button_flags[FlagLong] = 1'b1;
          r.button_flags[FlagJustLong] = !before_long;
        end
        r.held_time = now_dur;
      end else begin
        r.button_flags[FlagReleased] = 1'b1;
        if (down_before[b]) begin
          r.button_flags[FlagJustReleased] = 1'b1;
          r.button_flags[FlagLong] = before_long;
          r.held_time = before_dur;
        end
      end
      r.last_of_frame = (b == NumButtons - 1);
      button_results_q = {button_results_q, r};
    end
  endtask

  task automatic compare_word(input out_word_t got);
    out_word_t exp;
    if (button_results_q.size() == 0) begin
      $display("%0t: result word with none expected, got %h", $time, got);
      fails++;
    end else begin
      exp = button_results_q.pop_front();
      checked++;
      if (got.button_index !== exp.button_index) begin
        $display("%0t: button_index expected %0d got %0d", $time,
                 exp.button_index, got.button_index);
        fails++;
      end
      if (got.button_flags !== exp.button_flags) begin
        $display("%0t: button %0d flags expected %b got %b", $time,
                 exp.button_index, exp.button_flags, got.button_flags);
        fails++;
      end
      if (got.held_time !== exp.held_time) begin
        $display("%0t: button %0d held_time expected %0d got %0d", $time,
                 exp.button_index, exp.held_time, got.held_time);
        fails++;
      end
      if (got.last_of_frame !== exp.last_of_frame) begin
        $display("%0t: button %0d last_of_frame expected %b got %b", $time,
                 exp.button_index, exp.last_of_frame, got.last_of_frame);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_thr_ms     = LongPressReset;
      clock_ms        = '0;
      clock_before_ms = '0;
      for (int b = 0; b < NumButtons; b++) begin
        down_now[b]        = 1'b0;
        down_before[b]     = 1'b0;
        start_ms[b]        = '0;
        start_before_ms[b] = '0;
      end
      button_results_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        compare_word(out_word_i);
      end
      if (in_valid_i && !in_stall_i) begin
        classify_frame(in_word_i);
      end
      if (cfg_we_i) begin
        long_thr_ms = cfg_data_i;
      end
    end
  end

endmodule

// ===== dv/tb_button_press_long_press_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_button_press_long_press_classifier
// Drives frames of button masks and frame deltas into the classifier under
// several long-press thresholds, with bursty input, a receiver that stalls on
// its own pattern, one long receiver hold-off and a stretch of long holds
// with the receiver free; the checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module tb_button_press_long_press_classifier;
  import bplpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumButtons    = NumButtonsDefault;
  localparam int unsigned ClkPeriod     = 4;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned PhaseItems    = 60;
  localparam int unsigned NumPhases     = 7;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_word_t         in_word_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_word_t        out_word_o;
  logic             cfg_we_i    = 1'b0;
  logic [LongW-1:0] cfg_data_i  = '0;

  int unsigned      fail_count;
  int unsigned      pending_words;
  int unsigned      words_checked;

  logic [LongW-1:0] long_thr_ms   = LongPressReset;
  logic [MaskW-1:0] press_pattern = '0;
  int unsigned      frames_sent   = 0;
  int unsigned      thr_writes    = 0;
  int unsigned      burst_left    = 1;
  int unsigned      idle_cycles   = 0;
  bit               hold_off_req  = 1'b0;
  bit               hold_off_done = 1'b0;
  bit               rx_free       = 1'b0;

  always #(ClkPeriod / 2.0) clk_i = ~clk_i;

  button_press_long_press_classifier #(
    .NumButtons(NumButtons)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  bplpc_frame_checker #(
    .NumButtons(NumButtons)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_word_i      (in_word_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_word_i     (out_word_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending_words),
    .words_checked_o(words_checked)
  );

  function automatic in_word_t mk_frame(input logic [MaskW-1:0] p, input logic [MaskW-1:0] r,
                                        input logic [DeltaW-1:0] d);
    in_word_t w;
    w.pressed_mask = p;
    w.repeat_mask  = r;
    w.frame_delta  = d;
    return w;
  endfunction

  // holds evolve slowly so presses cross the threshold
  function automatic in_word_t pick_frame();
    in_word_t         w;
    logic [MaskW-1:0] flip;
    case ($urandom_range(0, 19))
      0: press_pattern = MaskW'($urandom);
      1: press_pattern = '0;
      2: press_pattern = '1;
      default: begin
        flip = MaskW'($urandom & $urandom & $urandom);
        press_pattern = press_pattern ^ flip;
      end
    endcase
    w.pressed_mask = press_pattern;
    w.repeat_mask  = MaskW'($urandom);
    case ($urandom_range(0, 9))
      0: w.frame_delta = '0;
      1: w.frame_delta = '1;
      2: w.frame_delta = DeltaW'($urandom_range(0, 65535));
      default: w.frame_delta = DeltaW'($urandom_range(0, int'(long_thr_ms / 3) + 1));
    endcase
    return w;
  endfunction

  task automatic send_frame(input in_word_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    frames_sent++;
  endtask

  task automatic offer_frame(input in_word_t w);
    send_frame(w);
    burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      in_word_i  <= in_word_t'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(20, 60)) @(negedge clk_i);
      end else begin
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic set_threshold(input logic [LongW-1:0] v);
    in_valid_i <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    long_thr_ms = v;
    thr_writes++;
  endtask

  // receiver free, button 0 held through large frame deltas
  task automatic run_long_holds();
    in_word_t w;
    rx_free = 1'b1;
    for (int k = 0; k < 16; k++) begin
      w = pick_frame();
      w.pressed_mask[0] = 1'b1;
      if (k < 8) begin
        w.frame_delta = '1;
      end else begin
        w.frame_delta = DeltaW'(20000);
      end
      send_frame(w);
    end
    rx_free = 1'b0;
  endtask

  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    mode      = 0;
    mode_left = 50;
    tick      = 0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else if (rx_free) begin
        out_stall_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 99) < 30);
          2: out_stall_i <= ($urandom_range(0, 99) < 80);
          default: out_stall_i <= ((tick % 8) < 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("button_press_long_press_classifier: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [LongW-1:0] phase_thr [NumPhases];
    phase_thr = '{16'd500, 16'd0, 16'hFFFF, 16'd1, 16'd40, 16'd1000, 16'd0};
    phase_thr[NumPhases-1] = LongW'($urandom_range(2, 65534));

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset threshold: short, exact, long and first-long release
    offer_frame(mk_frame(8'h00, 8'h00, 16'd0));
    offer_frame(mk_frame(8'hFF, 8'hFF, 16'd0));
    offer_frame(mk_frame(8'hFF, 8'h00, 16'd499));
    offer_frame(mk_frame(8'hFF, 8'h00, 16'd1));
    offer_frame(mk_frame(8'hFF, 8'h0F, 16'd100));
    offer_frame(mk_frame(8'h00, 8'hFF, 16'd10));
    offer_frame(mk_frame(8'h00, 8'h00, 16'd0));
    offer_frame(mk_frame(8'h55, 8'hAA, 16'hFFFF));
    offer_frame(mk_frame(8'hAA, 8'h55, 16'hFFFF));
    offer_frame(mk_frame(8'h0F, 8'h0F, 16'd10));
    offer_frame(mk_frame(8'h00, 8'h00, 16'd1000));

    // zero threshold
    set_threshold(16'd0);
    offer_frame(mk_frame(8'hF0, 8'hF0, 16'd0));
    offer_frame(mk_frame(8'hF0, 8'h00, 16'd5));
    offer_frame(mk_frame(8'h00, 8'hFF, 16'd3));

    // largest threshold
    set_threshold(16'hFFFF);
    offer_frame(mk_frame(8'h81, 8'h01, 16'hFFFF));
    offer_frame(mk_frame(8'h81, 8'h80, 16'd0));
    offer_frame(mk_frame(8'h80, 8'hFF, 16'hFFFE));
    offer_frame(mk_frame(8'h00, 8'h00, 16'd0));

    set_threshold(16'd1);
    offer_frame(mk_frame(8'h3C, 8'h00, 16'd0));
    offer_frame(mk_frame(8'h3C, 8'h3C, 16'd1));
    offer_frame(mk_frame(8'hC3, 8'hC3, 16'd2));
    offer_frame(mk_frame(8'hFF, 8'hFF, 16'hFFFF));

    for (int ph = 0; ph < NumPhases; ph++) begin
      set_threshold(phase_thr[ph]);
      if (ph == 2) begin
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        offer_frame(pick_frame());
      end
      if (ph == 3) begin
        run_long_holds();
      end
    end

    in_valid_i <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);

    $display("covered %0d frames and %0d result words over %0d threshold settings,",
             frames_sent, words_checked, thr_writes);
    $display("including a receiver hold-off and long holds with the receiver free");
    if (fail_count == 0 && pending_words == 0) begin
      $display("button_press_long_press_classifier: match");
    end else begin
      $display("button_press_long_press_classifier: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bplpc_pkg.sv
src/bplpc_lane.sv
src/bplpc_drain.sv
src/button_press_long_press_classifier.sv
dv/bplpc_frame_checker.sv
dv/tb_button_press_long_press_classifier.sv
